>>> src/ibus_rx_pkg.sv
// shared constants for the ibus frame receiver
package ibus_rx_pkg;

  localparam int FRAME_LENGTH = 32;
  localparam int ADDR_W       = $clog2(FRAME_LENGTH);
  localparam int SUM_BYTES    = 30;
  localparam int FIRST_CHAN   = 2;

  localparam logic [15:0] CHECK_INIT = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  localparam logic [1:0] KIND_CHANNEL  = 2'd0;
  localparam logic [1:0] KIND_CHECKSUM = 2'd1;
  localparam logic [1:0] KIND_RANGE    = 2'd2;

  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_MIN_VALID     = 2'd2;
  localparam logic [1:0] REG_MAX_VALID     = 2'd3;

  localparam logic [7:0]  HEADER_FIRST_RST  = 8'h20;
  localparam logic [7:0]  HEADER_SECOND_RST = 8'h40;
  localparam logic [15:0] MIN_VALID_RST     = 16'd900;
  localparam logic [15:0] MAX_VALID_RST     = 16'd2100;

endpackage

>>> src/ibus_rx_byte_if.sv
// valid/ready channel carrying one received byte per beat
interface ibus_rx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> src/ibus_rx_result_if.sv
// valid/ready channel carrying one decoded result per beat
interface ibus_rx_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  channel_index;
  logic [15:0] channel_value;
  logic        last;
  logic [15:0] bad_frames;

  modport source (output valid, output kind, output channel_index, output channel_value,
                  output last, output bad_frames, input ready);
  modport sink   (input valid, input kind, input channel_index, input channel_value,
                  input last, input bad_frames, output ready);
endinterface

>>> src/ibus_rx_frame_mem.sv
// frame byte store, one write port and one registered read port
module ibus_rx_frame_mem (
  input  logic                           clk,
  input  logic                           we,
  input  logic [ibus_rx_pkg::ADDR_W-1:0] waddr,
  input  logic [7:0]                     wdata,
  input  logic [ibus_rx_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                     rdata
);

  logic [7:0] mem [ibus_rx_pkg::FRAME_LENGTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/ibus_frame_receiver_top.sv
// ibus frame receiver: sync search, frame store, checksum and channel range check
//
// rx carries one received byte per beat; res carries decoded results.
// bytes that do not complete a frame are taken one per cycle. on the final
// (32nd) byte the block drops ready and runs its sequencer: a checksum compare,
// then a range pass and an emit pass over the frame store, each doing per channel
// two reads of the single store port, one word assembly, then a compare in the
// range pass or a result load in the emit pass. a bad checksum loads its error
// beat in the reject state after the checksum compare; a good frame gives one
// channel beat per channel in the emit pass. a range failure ends the range pass
// at the failing channel and gives one error beat. results wait in an output
// register; when the receiver stalls the sequencer holds before loading the next
// beat, and the next byte is taken as soon as the last beat of a frame is loaded,
// even while it still waits. reset (synchronous, active high) restores the
// registers to their defaults, clears the byte position and the bad-frame count,
// and empties the output. configuration is written through
// cfg_we/cfg_index/cfg_data while idle, a user rule the block does not enforce.
module ibus_frame_receiver_top #(
  parameter int NUM_CHANNELS = 14
) (
  input  logic                    clk,
  input  logic                    rst,
  ibus_rx_byte_if.sink            rx,
  ibus_rx_result_if.source        res,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_RLO  = 3'd2;
  localparam logic [2:0] S_RHI  = 3'd3;
  localparam logic [2:0] S_WORD = 3'd4;
  localparam logic [2:0] S_RCMP = 3'd5;
  localparam logic [2:0] S_REJ  = 3'd6;

  localparam int AW = ibus_rx_pkg::ADDR_W;
  localparam logic [AW-1:0] FIRST_ADDR = AW'(ibus_rx_pkg::FIRST_CHAN);
  localparam logic [AW-1:0] LAST_POS   = AW'(ibus_rx_pkg::FRAME_LENGTH - 1);
  localparam logic [AW-1:0] CHK_LO_POS = AW'(ibus_rx_pkg::SUM_BYTES);
  localparam logic [3:0]    LAST_CHAN  = 4'(NUM_CHANNELS - 1);

  logic [7:0]    header_first;
  logic [7:0]    header_second;
  logic [15:0]   min_valid;
  logic [15:0]   max_valid;

  logic [2:0]    state;
  logic [AW-1:0] pos;
  logic [AW-1:0] addr;
  logic [3:0]    chan;
  logic          emit_pass;
  logic [15:0]   bad_count;
  logic [15:0]   bad_count_next;

  logic [15:0]   sum;
  logic [15:0]   chk;
  logic [7:0]    lo;
  logic [15:0]   word;
  logic [1:0]    rej_kind;

  logic          o_valid;
  logic [1:0]    o_kind;
  logic [3:0]    o_index;
  logic [15:0]   o_value;
  logic          o_last;
  logic [15:0]   o_bad;

  logic          accept;
  logic          drop_first;
  logic          drop_second;
  logic          store;
  logic          slot;
  logic          word_ok;
  logic          last_chan;
  logic          load_chan;
  logic          load_rej;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  assign rx.ready    = (state == S_IDLE);
  assign accept      = rx.valid && rx.ready;
  assign drop_first  = (pos == '0) && (rx.rx_byte != header_first);
  assign drop_second = (pos == AW'(1)) && (rx.rx_byte != header_second);
  assign store       = accept && !drop_first && !drop_second;

  assign slot      = !o_valid || res.ready;
  assign word_ok   = (word >= min_valid) && (word <= max_valid);
  assign last_chan = (chan == LAST_CHAN);
  assign load_chan = (state == S_RCMP) && emit_pass && slot;
  assign load_rej  = (state == S_REJ) && slot;
  assign raddr     = (state == S_RHI) ? (addr | AW'(1)) : addr;

  assign bad_count_next = (bad_count == ibus_rx_pkg::COUNT_MAX) ? bad_count
                                                                : bad_count + 16'd1;

  ibus_rx_frame_mem u_mem (
    .clk   (clk),
    .we    (store),
    .waddr (pos),
    .wdata (rx.rx_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= ibus_rx_pkg::HEADER_FIRST_RST;
      header_second <= ibus_rx_pkg::HEADER_SECOND_RST;
      min_valid     <= ibus_rx_pkg::MIN_VALID_RST;
      max_valid     <= ibus_rx_pkg::MAX_VALID_RST;
      state         <= S_IDLE;
      pos           <= '0;
      addr          <= FIRST_ADDR;
      chan          <= '0;
      emit_pass     <= 1'b0;
      bad_count     <= '0;
      o_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ibus_rx_pkg::REG_HEADER_FIRST:  header_first  <= cfg_data[7:0];
          ibus_rx_pkg::REG_HEADER_SECOND: header_second <= cfg_data[7:0];
          ibus_rx_pkg::REG_MIN_VALID:     min_valid     <= cfg_data;
          ibus_rx_pkg::REG_MAX_VALID:     max_valid     <= cfg_data;
          default: ;
        endcase
      end

      if (load_chan || load_rej) begin
        o_valid <= 1'b1;
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && drop_second) begin
            pos <= '0;
          end else if (store) begin
            pos <= pos + AW'(1);
            if (pos == LAST_POS) begin
              state <= S_SUM;
            end
          end
        end
        S_SUM: begin
          addr      <= FIRST_ADDR;
          chan      <= '0;
          emit_pass <= 1'b0;
          state     <= (sum != chk) ? S_REJ : S_RLO;
        end
        S_RLO:  state <= S_RHI;
        S_RHI:  state <= S_WORD;
        S_WORD: state <= S_RCMP;
        S_RCMP: begin
          if (!emit_pass) begin
            if (!word_ok) begin
              state <= S_REJ;
            end else if (last_chan) begin
              emit_pass <= 1'b1;
              chan      <= '0;
              addr      <= FIRST_ADDR;
              state     <= S_RLO;
            end else begin
              chan  <= chan + 4'd1;
              addr  <= addr + AW'(2);
              state <= S_RLO;
            end
          end else if (slot) begin
            if (last_chan) begin
              state <= S_IDLE;
            end else begin
              chan  <= chan + 4'd1;
              addr  <= addr + AW'(2);
              state <= S_RLO;
            end
          end
        end
        S_REJ: begin
          if (slot) begin
            bad_count <= bad_count_next;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (store) begin
      if (pos == '0) begin
        sum <= ibus_rx_pkg::CHECK_INIT - {8'd0, rx.rx_byte};
      end else if (pos < CHK_LO_POS) begin
        sum <= sum - {8'd0, rx.rx_byte};
      end
      if (pos == CHK_LO_POS) begin
        chk[7:0] <= rx.rx_byte;
      end
      if (pos == LAST_POS) begin
        chk[15:8] <= rx.rx_byte;
      end
    end

    if (state == S_SUM) begin
      rej_kind <= ibus_rx_pkg::KIND_CHECKSUM;
    end else if (state == S_RCMP && !emit_pass) begin
      rej_kind <= ibus_rx_pkg::KIND_RANGE;
    end

    if (state == S_RHI) begin
      lo <= rdata;
    end
    if (state == S_WORD) begin
      word <= {rdata, lo};
    end

    if (load_chan) begin
      o_kind  <= ibus_rx_pkg::KIND_CHANNEL;
      o_index <= chan;
      o_value <= word;
      o_last  <= last_chan;
      o_bad   <= bad_count;
    end else if (load_rej) begin
      o_kind  <= rej_kind;
      o_index <= '0;
      o_value <= '0;
      o_last  <= 1'b1;
      o_bad   <= bad_count_next;
    end
  end

  assign res.valid         = o_valid;
  assign res.kind          = o_kind;
  assign res.channel_index = o_index;
  assign res.channel_value = o_value;
  assign res.last          = o_last;
  assign res.bad_frames    = o_bad;

`ifndef NO_ASSERTIONS
  a_bad_count_monotone: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> bad_count >= $past(bad_count))
    else $error("bad-frame count went down");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind != ibus_rx_pkg::KIND_CHANNEL) |-> res.last)
    else $error("error beat not marked last");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == ibus_rx_pkg::KIND_CHANNEL) |-> res.channel_index <= LAST_CHAN)
    else $error("channel index beyond channel count");

  a_frame_end_checks: assert property (@(posedge clk) disable iff (rst)
    (accept && pos == LAST_POS) |=> state == S_SUM)
    else $error("final byte did not start the frame check");
`endif

endmodule
